/* design/mctb_pkg.sv */
package mctb_pkg;

   // Fixed field widths of the transaction payloads
   localparam int KIND_W  = 4;
   localparam int ID_W    = 4;
   localparam int TICKS_W = 32;
   localparam int TIU_W   = 5;
   localparam int MAX_IDS = 16;

   localparam logic [TIU_W-1:0] TIU_RESET = TIU_W'(1);

   // Default generics for the top level
   localparam int NUM_TIMERS_DEF = 16;
   localparam int COUNT_BITS_DEF = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK        = 4'd0,
      KIND_START       = 4'd1,
      KIND_CREATE      = 4'd2,
      KIND_STOP        = 4'd3,
      KIND_PLAY        = 4'd4,
      KIND_RESTART     = 4'd5,
      KIND_FINISH      = 4'd6,
      KIND_RESET       = 4'd7,
      KIND_ACTIVATE    = 4'd8,
      KIND_SET_PERIOD  = 4'd9,
      KIND_SET_NOTIFY  = 4'd10,
      KIND_READ_EXP    = 4'd11
   } kind_type;

   // Result event codes
   localparam logic EV_FIRED    = 1'b0;
   localparam logic EV_READ_EXP = 1'b1;

   typedef struct packed {
      logic running;
      logic expired;
      logic periodic;
      logic notify;
   } timer_flags_type;

endpackage

/* design/mctb_req_if.sv */
interface mctb_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [3:0]  timer_id;
   logic [31:0] ticks;
   logic        mode;
   logic        notify_enable;

   modport source (output valid, kind, timer_id, ticks, mode, notify_enable, input ready);
   modport sink   (input valid, kind, timer_id, ticks, mode, notify_enable, output ready);
endinterface

/* design/mctb_rsp_if.sv */
interface mctb_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_res;
   logic [3:0] which_timer;
   logic       was_expired;
   logic       last;

   modport source (output valid, event_res, which_timer, was_expired, last, input ready);
   modport sink   (input valid, event_res, which_timer, was_expired, last, output ready);
endinterface

/* design/mctb_store.sv */
module mctb_store #(
   parameter int DEPTH      = 16,
   parameter int COUNT_BITS = 32,
   parameter int IDX_W      = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [IDX_W-1:0]              rd_idx,
   output logic [COUNT_BITS-1:0]         rd_count,
   output logic [COUNT_BITS-1:0]         rd_period,
   output mctb_pkg::timer_flags_type     rd_flags,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_idx,
   input  logic [COUNT_BITS-1:0]         wr_count,
   input  logic [COUNT_BITS-1:0]         wr_period,
   input  mctb_pkg::timer_flags_type     wr_flags
);
   import mctb_pkg::*;

   logic [COUNT_BITS-1:0] count_ff  [DEPTH];
   logic [COUNT_BITS-1:0] period_ff [DEPTH];
   timer_flags_type       flags_ff  [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            count_ff[i]  <= '0;
            period_ff[i] <= '0;
            flags_ff[i]  <= '0;
         end
      end else if (wr_en) begin
         count_ff[wr_idx]  <= wr_count;
         period_ff[wr_idx] <= wr_period;
         flags_ff[wr_idx]  <= wr_flags;
      end
   end

   assign rd_count  = count_ff[rd_idx];
   assign rd_period = period_ff[rd_idx];
   assign rd_flags  = flags_ff[rd_idx];

endmodule

/* design/mctb_seq.sv */
module mctb_seq #(
   parameter int DEPTH      = 16,
   parameter int COUNT_BITS = 32,
   parameter int IDX_W      = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   mctb_req_if.sink                      req_if,
   mctb_rsp_if.source                    rsp_if,
   input  logic [mctb_pkg::TIU_W-1:0]    timers_in_use,
   output logic [IDX_W-1:0]              rd_idx,
   input  logic [COUNT_BITS-1:0]         rd_count,
   input  logic [COUNT_BITS-1:0]         rd_period,
   input  mctb_pkg::timer_flags_type     rd_flags,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_idx,
   output logic [COUNT_BITS-1:0]         wr_count,
   output logic [COUNT_BITS-1:0]         wr_period,
   output mctb_pkg::timer_flags_type     wr_flags
);
   import mctb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMD  = 3'b010,
      ST_TICK = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   kind_type              kind_ff;
   logic [ID_W-1:0]       id_ff;
   logic [COUNT_BITS-1:0] ticks_ff;
   logic                  mode_ff;
   logic                  notify_ff;
   logic [TIU_W-1:0]      walk_ff, walk_in;     // timers left to visit
   logic                  pend_ff, pend_in;     // fired event held back for last flag
   logic [ID_W-1:0]       pend_id_ff, pend_id_in;

   logic                  rsp_valid_ff;
   logic                  rsp_event_ff;
   logic [ID_W-1:0]       rsp_timer_ff;
   logic                  rsp_expired_ff;
   logic                  rsp_last_ff;

   logic                  emit;
   logic                  emit_event;
   logic [ID_W-1:0]       emit_timer;
   logic                  emit_expired;
   logic                  emit_last;

   logic [TIU_W-1:0]      lim;
   logic [TIU_W-1:0]      visit;
   logic [IDX_W-1:0]      visit_idx;
   logic [IDX_W-1:0]      item_idx;
   logic                  id_ok;
   logic                  out_free;
   logic [COUNT_BITS-1:0] dec;
   logic                  hit;
   logic                  fire;
   logic                  accept;

   assign lim       = (timers_in_use > TIU_W'(DEPTH)) ? TIU_W'(DEPTH) : timers_in_use;
   assign visit     = walk_ff - TIU_W'(1);
   assign visit_idx = visit[IDX_W-1:0];
   assign item_idx  = id_ff[IDX_W-1:0];
   assign id_ok     = {1'b0, id_ff} < TIU_W'(DEPTH);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign accept    = req_if.valid && req_if.ready;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rd_idx       = (state_ff == ST_TICK) ? visit_idx : item_idx;
   assign wr_idx       = rd_idx;

   // shared decrement and zero-detect unit
   assign dec  = rd_count - COUNT_BITS'(1);
   assign hit  = rd_flags.running && (rd_count != '0);
   assign fire = hit && (dec == '0);

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      wr_en        = 1'b0;
      wr_count     = rd_count;
      wr_period    = rd_period;
      wr_flags     = rd_flags;
      emit         = 1'b0;
      emit_event   = EV_FIRED;
      emit_timer   = id_ff;
      emit_expired = 1'b0;
      emit_last    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (kind_type'(req_if.kind) == KIND_TICK) begin
                  state_in = ST_TICK;
                  walk_in  = lim;
                  pend_in  = 1'b0;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end

         ST_CMD: begin
            state_in = ST_IDLE;
            case (kind_ff)
               KIND_START, KIND_CREATE: begin
                  if ({1'b0, id_ff} < lim) begin
                     wr_en             = 1'b1;
                     wr_count          = ticks_ff;
                     wr_period         = ticks_ff;
                     wr_flags.running  = (kind_ff == KIND_START);
                     wr_flags.expired  = 1'b0;
                     wr_flags.periodic = mode_ff;
                     wr_flags.notify   = notify_ff;
                  end
               end
               KIND_STOP: begin
                  wr_en            = id_ok;
                  wr_flags.running = 1'b0;
                  wr_flags.expired = 1'b0;
               end
               KIND_PLAY: begin
                  wr_en            = id_ok;
                  wr_flags.running = 1'b1;
               end
               KIND_RESTART, KIND_ACTIVATE: begin
                  wr_en            = id_ok;
                  wr_count         = rd_period;
                  wr_flags.running = 1'b1;
                  wr_flags.expired = 1'b0;
               end
               KIND_FINISH: begin
                  if (id_ok && rd_flags.notify && !out_free) begin
                     state_in = ST_CMD;
                  end else begin
                     wr_en            = id_ok;
                     wr_count         = '0;
                     wr_flags.running = 1'b0;
                     wr_flags.expired = 1'b1;
                     emit             = id_ok && rd_flags.notify;
                  end
               end
               KIND_RESET: begin
                  wr_en            = id_ok;
                  wr_count         = rd_period;
                  wr_flags.running = 1'b0;
                  wr_flags.expired = 1'b0;
               end
               KIND_SET_PERIOD: begin
                  wr_en            = id_ok;
                  wr_count         = ticks_ff;
                  wr_period        = ticks_ff;
                  wr_flags.running = 1'b1;
                  wr_flags.expired = 1'b0;
               end
               KIND_SET_NOTIFY: begin
                  wr_en            = id_ok;
                  wr_count         = rd_period;
                  wr_flags.notify  = notify_ff;
                  wr_flags.running = 1'b1;
                  wr_flags.expired = 1'b0;
               end
               KIND_READ_EXP: begin
                  if (!out_free) begin
                     state_in = ST_CMD;
                  end else begin
                     wr_en            = id_ok;
                     wr_flags.expired = 1'b0;
                     emit             = 1'b1;
                     emit_event       = EV_READ_EXP;
                     emit_expired     = id_ok && rd_flags.expired;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_TICK: begin
            if (walk_ff == '0) begin
               // walk done: flush the held event as the final one
               if (pend_ff) begin
                  if (out_free) begin
                     emit       = 1'b1;
                     emit_timer = pend_id_ff;
                     pend_in    = 1'b0;
                     state_in   = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!(fire && rd_flags.notify && pend_ff && !out_free)) begin
               walk_in = visit;
               if (hit) begin
                  wr_en    = 1'b1;
                  wr_count = dec;
                  if (fire) begin
                     if (rd_flags.periodic) begin
                        wr_count = rd_period;
                     end else begin
                        wr_flags.running = 1'b0;
                        wr_flags.expired = 1'b1;
                     end
                     if (rd_flags.notify) begin
                        emit       = pend_ff;
                        emit_timer = pend_id_ff;
                        emit_last  = 1'b0;
                        pend_in    = 1'b1;
                        pend_id_in = ID_W'(visit_idx);
                     end
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         pend_ff  <= pend_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff <= pend_id_in;
      if (accept) begin
         kind_ff   <= kind_type'(req_if.kind);
         id_ff     <= req_if.timer_id;
         ticks_ff  <= COUNT_BITS'(req_if.ticks);
         mode_ff   <= req_if.mode;
         notify_ff <= req_if.notify_enable;
      end
      if (emit) begin
         rsp_event_ff   <= emit_event;
         rsp_timer_ff   <= emit_timer;
         rsp_expired_ff <= emit_expired;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.event_res   = rsp_event_ff;
   assign rsp_if.which_timer = rsp_timer_ff;
   assign rsp_if.was_expired = rsp_expired_ff;
   assign rsp_if.last        = rsp_last_ff;

endmodule

/* design/multi_channel_timer_bank_core.sv */
// Bank of down-counting software-style timers (one-shot or periodic) driven by
// a stream of transactions on req_if: a tick, or a command aimed at one timer.
// Results (fired events and read-expired answers) leave on rsp_if, with last
// set on the final result of each transaction. The block takes one request
// at a time. A command is accepted, then does one read-modify-write of the
// timer store. A tick walks the in-use timers (the in-use count capped at the
// bank size): the sequencer visits one timer per cycle, highest id first,
// through a single shared decrement/zero-detect unit and the single
// read/write port of the timer store, and stalls whenever a result must leave
// while the output register is still held by rsp_if.ready low.
// The in-use count is taken from csr_wr_data when csr_wr_en is high; write it
// only while the block is idle. Reset is synchronous and clears every timer.
module multi_channel_timer_bank_core #(
   parameter int NUM_TIMERS = mctb_pkg::NUM_TIMERS_DEF,
   parameter int COUNT_BITS = mctb_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mctb_req_if.sink                      req_if,
   mctb_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [mctb_pkg::TIU_W-1:0]    csr_wr_data
);
   import mctb_pkg::*;

   // Ids are 4 bits wide, so no more than 16 timers are ever reachable
   localparam int DEPTH = (NUM_TIMERS < MAX_IDS) ? NUM_TIMERS : MAX_IDS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [TIU_W-1:0]       timers_in_use_ff;

   logic [IDX_W-1:0]       rd_idx;
   logic [COUNT_BITS-1:0]  rd_count;
   logic [COUNT_BITS-1:0]  rd_period;
   timer_flags_type        rd_flags;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;
   logic [COUNT_BITS-1:0]  wr_count;
   logic [COUNT_BITS-1:0]  wr_period;
   timer_flags_type        wr_flags;

   // configuration: number of allocated timers
   always_ff @(posedge clock) begin
      if (reset) begin
         timers_in_use_ff <= TIU_RESET;
      end else if (csr_wr_en) begin
         timers_in_use_ff <= csr_wr_data;
      end
   end

   // per-timer count, period and flag store
   mctb_store #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx),
      .rd_count  (rd_count),
      .rd_period (rd_period),
      .rd_flags  (rd_flags),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_count  (wr_count),
      .wr_period (wr_period),
      .wr_flags  (wr_flags)
   );

   // sequencer: command decode, tick walk and result register
   mctb_seq #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .timers_in_use (timers_in_use_ff),
      .rd_idx        (rd_idx),
      .rd_count      (rd_count),
      .rd_period     (rd_period),
      .rd_flags      (rd_flags),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_count      (wr_count),
      .wr_period     (wr_period),
      .wr_flags      (wr_flags)
   );

endmodule
